FILE: rtl/qts_pkg.sv
// Shared types, constants and character-class functions for the query token scanner.
package qts_pkg;

   localparam int MAX_STATEMENT_DEF = 4096;
   localparam int CH_W              = 8;
   localparam int OFF_W             = 12;
   localparam int LEN_W             = 13;
   localparam int KW_NUM            = 3;
   localparam int KW_SLOTS          = 8;

   typedef enum logic [3:0] {
      KIND_IDENT   = 4'd0,
      KIND_SELECT  = 4'd1,
      KIND_FROM    = 4'd2,
      KIND_WHERE   = 4'd3,
      KIND_INTEGER = 4'd4,
      KIND_OPEN    = 4'd5,
      KIND_CLOSE   = 4'd6,
      KIND_SEMI    = 4'd7,
      KIND_EQUALS  = 4'd8,
      KIND_END     = 4'd9,
      KIND_ERROR   = 4'd10
   } kind_type;

   localparam logic [CH_W-1:0] CH_OPEN   = 8'h28;
   localparam logic [CH_W-1:0] CH_CLOSE  = 8'h29;
   localparam logic [CH_W-1:0] CH_SEMI   = 8'h3B;
   localparam logic [CH_W-1:0] CH_EQUALS = 8'h3D;
   localparam logic [CH_W-1:0] CH_SPACE  = 8'h20;

   // Keyword spellings, padded with zeros to a power-of-two row
   localparam logic [CH_W-1:0] KW_TEXT [KW_NUM][KW_SLOTS] = '{
      '{8'h73, 8'h65, 8'h6C, 8'h65, 8'h63, 8'h74, 8'h00, 8'h00},  // select
      '{8'h66, 8'h72, 8'h6F, 8'h6D, 8'h00, 8'h00, 8'h00, 8'h00},  // from
      '{8'h77, 8'h68, 8'h65, 8'h72, 8'h65, 8'h00, 8'h00, 8'h00}   // where
   };
   localparam logic [3:0] KW_LEN [KW_NUM] = '{4'd6, 4'd4, 4'd5};

   // One input byte and its end-of-statement flag
   typedef struct packed {
      logic [CH_W-1:0] ch;
      logic            final_byte;
   } item_type;

   // One token as delivered on the result channel
   typedef struct packed {
      kind_type         kind;
      logic [OFF_W-1:0] start_offset;
      logic [LEN_W-1:0] token_length;
      logic             last_of_run;
   } result_type;

   // All tokens caused by one input byte, packed from entry 0
   typedef struct packed {
      result_type [2:0] entry;
      logic [1:0]       count;
   } run_type;

   function automatic logic is_letter(input logic [CH_W-1:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_digit(input logic [CH_W-1:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_blank(input logic [CH_W-1:0] c);
      return (c >= 8'h09 && c <= 8'h0D) || c == CH_SPACE;
   endfunction

   // Keywords whose character at position idx equals c
   function automatic logic [KW_NUM-1:0] kw_match(input logic [2:0] idx,
                                                  input logic [CH_W-1:0] c);
      logic [KW_NUM-1:0] m;
      m = '0;
      for (int k = 0; k < KW_NUM; k++) begin
         if ({1'b0, idx} < KW_LEN[k] && KW_TEXT[k][idx] == c) begin
            m[k] = 1'b1;
         end
      end
      return m;
   endfunction

   // Class a finished word from its keywords still matching at full length
   function automatic kind_type word_kind(input logic [KW_NUM-1:0] hit);
      kind_type k;
      priority if (hit[0]) begin
         k = KIND_SELECT;
      end else if (hit[1]) begin
         k = KIND_FROM;
      end else if (hit[2]) begin
         k = KIND_WHERE;
      end else begin
         k = KIND_IDENT;
      end
      return k;
   endfunction

endpackage

FILE: rtl/qts_if.sv
// Handshake channel interfaces for statement bytes and tokens.
interface qts_req_if;
   logic                     valid;
   logic                     ready;
   logic [qts_pkg::CH_W-1:0] ch;
   logic                     final_byte;

   modport source (output valid, output ch, output final_byte, input ready);
   modport sink (input valid, input ch, input final_byte, output ready);
endinterface

interface qts_rsp_if;
   logic                      valid;
   logic                      ready;
   qts_pkg::kind_type         kind;
   logic [qts_pkg::OFF_W-1:0] start_offset;
   logic [qts_pkg::LEN_W-1:0] token_length;
   logic                      last_of_run;

   modport source (output valid, output kind, output start_offset, output token_length,
                   output last_of_run, input ready);
   modport sink (input valid, input kind, input start_offset, input token_length,
                 input last_of_run, output ready);
endinterface

FILE: rtl/qts_input_stage.sv
// Input register that holds one statement byte until the scanner takes it.
module qts_input_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  qts_pkg::item_type req_item,
   input  logic              space,
   output logic              go,
   output qts_pkg::item_type item
);

   logic              valid_ff, valid_in;
   qts_pkg::item_type item_ff, item_in;
   logic              take;

   // Move the held item on when the result side has room
   assign go        = valid_ff && space;
   assign req_ready = !valid_ff || space;
   assign take      = req_valid && req_ready;
   assign item      = item_ff;

   always_comb begin
      valid_in = take ? 1'b1 : (go ? 1'b0 : valid_ff);
      item_in  = take ? req_item : item_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

endmodule

FILE: rtl/qts_scan_core.sv
// Scanner state and the single-pass logic that turns one byte into its tokens.
module qts_scan_core #(
   parameter int MAX_STATEMENT = qts_pkg::MAX_STATEMENT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  qts_pkg::item_type item,
   output qts_pkg::run_type  run
);

   localparam int POS_W = $clog2(MAX_STATEMENT);
   localparam int CNT_W = $clog2(MAX_STATEMENT + 1);
   localparam int OFF_W = qts_pkg::OFF_W;
   localparam int LEN_W = qts_pkg::LEN_W;
   localparam int KW_NUM = qts_pkg::KW_NUM;
   localparam logic [POS_W-1:0] POS_TOP = POS_W'(MAX_STATEMENT - 1);
   localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(MAX_STATEMENT);

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_WORD   = 2'd1,
      MODE_NUMBER = 2'd2,
      MODE_SKIP   = 2'd3
   } mode_type;

   mode_type          mode_ff, mode_in;
   logic [POS_W-1:0]  start_ff, start_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [KW_NUM-1:0] alive_ff, alive_in;

   logic                letter, digit, blank, absorb;
   logic [POS_W-1:0]    pos_next;
   logic [CNT_W-1:0]    cnt_next;
   logic [KW_NUM-1:0]   keep_mask, hit_old, hit_new;
   mode_type            m2;
   logic [POS_W-1:0]    s2;
   logic [CNT_W-1:0]    c2;
   logic [KW_NUM-1:0]   a2;
   logic [2:0]          slot_v;
   qts_pkg::result_type slot [3];
   qts_pkg::result_type single;
   logic                single_v;
   logic [1:0]          n;
   qts_pkg::run_type    run_c;

   always_comb begin
      letter = qts_pkg::is_letter(item.ch);
      digit  = qts_pkg::is_digit(item.ch);
      blank  = qts_pkg::is_blank(item.ch);
      absorb = (mode_ff == MODE_WORD && (letter || digit)) ||
               (mode_ff == MODE_NUMBER && digit) || mode_ff == MODE_SKIP;

      // Saturating steps of offset and length
      pos_next = (pos_ff >= POS_TOP) ? POS_TOP : pos_ff + POS_W'(1);
      cnt_next = (cnt_ff >= CNT_TOP) ? CNT_TOP : cnt_ff + CNT_W'(1);

      // Keywords still alive after this character, and length hits
      keep_mask = (cnt_ff < CNT_W'(qts_pkg::KW_SLOTS)) ?
                  qts_pkg::kw_match(cnt_ff[2:0], item.ch) : '0;
      for (int k = 0; k < KW_NUM; k++) begin
         hit_old[k] = cnt_ff == CNT_W'(qts_pkg::KW_LEN[k]);
      end

      // Flush of the token pending before this byte
      slot_v[0] = !absorb && (mode_ff == MODE_WORD || mode_ff == MODE_NUMBER);
      slot[0].kind = (mode_ff == MODE_WORD) ? qts_pkg::word_kind(alive_ff & hit_old)
                                            : qts_pkg::KIND_INTEGER;
      slot[0].start_offset = OFF_W'(start_ff);
      slot[0].token_length = LEN_W'(cnt_ff);
      slot[0].last_of_run  = 1'b0;

      // Absorb into the pending token, or scan the byte fresh
      m2 = mode_ff;
      s2 = start_ff;
      c2 = cnt_ff;
      a2 = alive_ff;
      single_v = 1'b0;
      single.kind = qts_pkg::KIND_ERROR;
      single.start_offset = OFF_W'(pos_ff);
      single.token_length = LEN_W'(1);
      single.last_of_run  = 1'b0;
      if (absorb) begin
         if (mode_ff == MODE_WORD) begin
            a2 = alive_ff & keep_mask;
            c2 = cnt_next;
         end else if (mode_ff == MODE_NUMBER) begin
            c2 = cnt_next;
         end
      end else begin
         m2 = MODE_IDLE;
         priority if (blank) begin
            m2 = MODE_IDLE;
         end else if (letter) begin
            m2 = MODE_WORD;
            s2 = pos_ff;
            c2 = CNT_W'(1);
            a2 = qts_pkg::kw_match(3'd0, item.ch);
         end else if (digit) begin
            m2 = MODE_NUMBER;
            s2 = pos_ff;
            c2 = CNT_W'(1);
         end else if (item.ch == qts_pkg::CH_OPEN) begin
            single_v = 1'b1;
            single.kind = qts_pkg::KIND_OPEN;
         end else if (item.ch == qts_pkg::CH_CLOSE) begin
            single_v = 1'b1;
            single.kind = qts_pkg::KIND_CLOSE;
         end else if (item.ch == qts_pkg::CH_SEMI) begin
            single_v = 1'b1;
            single.kind = qts_pkg::KIND_SEMI;
         end else if (item.ch == qts_pkg::CH_EQUALS) begin
            single_v = 1'b1;
            single.kind = qts_pkg::KIND_EQUALS;
         end else begin
            single_v = 1'b1;
            single.kind = qts_pkg::KIND_ERROR;
            m2 = MODE_SKIP;
         end
      end

      // Middle slot: a single-byte token, or the flush forced by the final byte
      for (int k = 0; k < KW_NUM; k++) begin
         hit_new[k] = c2 == CNT_W'(qts_pkg::KW_LEN[k]);
      end
      if (single_v) begin
         slot_v[1] = 1'b1;
         slot[1]   = single;
      end else begin
         slot_v[1] = item.final_byte && (m2 == MODE_WORD || m2 == MODE_NUMBER);
         slot[1].kind = (m2 == MODE_WORD) ? qts_pkg::word_kind(a2 & hit_new)
                                          : qts_pkg::KIND_INTEGER;
         slot[1].start_offset = OFF_W'(s2);
         slot[1].token_length = LEN_W'(c2);
         slot[1].last_of_run  = 1'b0;
      end

      // End token just past the final byte
      slot_v[2] = item.final_byte;
      slot[2].kind = qts_pkg::KIND_END;
      slot[2].start_offset = OFF_W'(pos_next);
      slot[2].token_length = '0;
      slot[2].last_of_run  = 1'b0;

      // Pack the valid slots in order and mark the last one
      run_c = '0;
      n = 2'd0;
      for (int s = 0; s < 3; s++) begin
         if (slot_v[s]) begin
            run_c.entry[n] = slot[s];
            n = n + 2'd1;
         end
      end
      if (n != 2'd0) begin
         run_c.entry[n - 2'd1].last_of_run = 1'b1;
      end
      run_c.count = n;

      // Next state: back to reset after the final byte
      if (item.final_byte) begin
         mode_in  = MODE_IDLE;
         start_in = '0;
         cnt_in   = '0;
         pos_in   = '0;
         alive_in = '1;
      end else begin
         mode_in  = m2;
         start_in = s2;
         cnt_in   = c2;
         pos_in   = pos_next;
         alive_in = a2;
      end
   end

   assign run = run_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_IDLE;
         start_ff <= '0;
         cnt_ff   <= '0;
         pos_ff   <= '0;
         alive_ff <= '1;
      end else if (go) begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         cnt_ff   <= cnt_in;
         pos_ff   <= pos_in;
         alive_ff <= alive_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_final_resets: assert property (@(posedge clock) disable iff (reset)
      go && item.final_byte |=> mode_ff == MODE_IDLE && pos_ff == '0 && cnt_ff == '0)
      else $error("scanner state not cleared after final byte");

   a_skip_holds: assert property (@(posedge clock) disable iff (reset)
      go && !item.final_byte && mode_ff == MODE_SKIP |=> mode_ff == MODE_SKIP)
      else $error("skip mode left before end of statement");
`endif

endmodule

FILE: rtl/qts_result_queue.sv
// Result register holding the tokens of one byte and draining them one per cycle while the sink is ready.
module qts_result_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  qts_pkg::run_type    run,
   output logic                space,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output qts_pkg::result_type rsp_item
);

   qts_pkg::result_type res_ff [3];
   qts_pkg::result_type res_in [3];
   logic [1:0]          count_ff, count_in;
   logic                pop;

   // Room for a new run once the queue empties this cycle
   assign pop       = count_ff != 2'd0 && rsp_ready;
   assign space     = count_ff == 2'd0 || (count_ff == 2'd1 && rsp_ready);
   assign rsp_valid = count_ff != 2'd0;
   assign rsp_item  = res_ff[0];

   always_comb begin
      res_in   = res_ff;
      count_in = count_ff;
      if (go) begin
         for (int i = 0; i < 3; i++) begin
            res_in[i] = run.entry[i];
         end
         count_in = run.count;
      end else if (pop) begin
         res_in[0] = res_ff[1];
         res_in[1] = res_ff[2];
         count_in  = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      res_ff <= res_in;
   end

`ifndef NO_ASSERTIONS
   a_hold_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_item))
      else $error("token changed while waiting for the sink");

   a_load_empty: assert property (@(posedge clock) disable iff (reset)
      go |-> count_ff == 2'd0 || (count_ff == 2'd1 && pop))
      else $error("run loaded over undelivered tokens");

   a_last_marked: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd1 |-> res_ff[0].last_of_run)
      else $error("final token of a run lacks its end mark");
`endif

endmodule

FILE: rtl/query_token_scanner.sv
// Top level of the query token scanner: input register, scan logic, result queue.
//
//   channel   direction  payload
//   req_bus   in         ch (8), final_byte (1)
//   rsp_bus   out        kind (4), start_offset (12), token_length (13), last_of_run (1)
//
// One byte per cycle while rsp_bus is ready; a byte with several tokens holds
// the result queue until they drain, and the input stalls meanwhile. Reset is
// synchronous and clears the scanner state and both stages.
// rsp_bus stalls back up through the result queue into the input register.
module query_token_scanner #(
   parameter int MAX_STATEMENT = qts_pkg::MAX_STATEMENT_DEF
) (
   input  logic             clock,
   input  logic             reset,
   qts_req_if.sink          req_bus,
   qts_rsp_if.source        rsp_bus
);

   qts_pkg::item_type   req_item, item;
   qts_pkg::run_type    run;
   qts_pkg::result_type rsp_item;
   logic                space, go;

   assign req_item.ch         = req_bus.ch;
   assign req_item.final_byte = req_bus.final_byte;

   qts_input_stage u_input (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req_item  (req_item),
      .space     (space),
      .go        (go),
      .item      (item)
   );

   qts_scan_core #(
      .MAX_STATEMENT (MAX_STATEMENT)
   ) u_core (
      .clock (clock),
      .reset (reset),
      .go    (go),
      .item  (item),
      .run   (run)
   );

   qts_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .run       (run),
      .space     (space),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_item  (rsp_item)
   );

   // Drive the result channel from the queue head
   assign rsp_bus.kind         = rsp_item.kind;
   assign rsp_bus.start_offset = rsp_item.start_offset;
   assign rsp_bus.token_length = rsp_item.token_length;
   assign rsp_bus.last_of_run  = rsp_item.last_of_run;

endmodule
